/* hdl/running_median_sum_macros.svh */
// ----------------------------------------------------------------------------
// running_median_sum_macros.svh
// Assertion macros for the running median block. Both forms clock on aclk
// and are disabled while aresetn is low. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_SUM_MACROS_SVH
`define RUNNING_MEDIAN_SUM_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define RMS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);
// A consequence that must hold in the cycle after its antecedent.
`define RMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMS_ASSERT_ALWAYS(lbl, cond, msg)
`define RMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/rms_pkg.sv */
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, constants and types of the running median block.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HALF_DEPTH = CAPACITY / 2;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int SAMPLE_W   = 32;
    localparam int TOTAL_W    = 42;
    localparam int MOD_W      = 15;
    localparam int HELD_W     = 11;

    localparam logic [CNT_W:0] CAPACITY_SUM = (CNT_W + 1)'(CAPACITY);

    // Remainder unit: the total magnitude is split into three 14-bit chunks
    // and folded with the residues of 2^14 and 2^28, which leaves a value
    // below 2^28 with the same remainder. A reciprocal multiply then gives
    // the exact quotient of that value, and a subtract leaves the remainder.
    localparam int MOD_BASE    = 10000;
    localparam int REM_W       = 14;
    localparam int FOLD_CHUNK  = TOTAL_W / 3;
    localparam int FOLD_W      = 2 * FOLD_CHUNK;
    localparam int FOLD_MID    = (1 << FOLD_CHUNK) % MOD_BASE;
    localparam int FOLD_HI     = (1 << FOLD_W) % MOD_BASE;
    localparam int RECIP_SHIFT = FOLD_W + REM_W;
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = FOLD_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int MOD_STAGES  = 5;

    localparam longint RECIP_FULL =
        ((longint'(1) << RECIP_SHIFT) + longint'(MOD_BASE) - longint'(1))
        / longint'(MOD_BASE);
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'(RECIP_FULL);

    localparam logic signed [MOD_W-1:0] MOD_LIMIT = MOD_W'(MOD_BASE);

    localparam int IN_DATA_W    = SAMPLE_W;
    localparam int OUT_FIELDS_W = SAMPLE_W + TOTAL_W + MOD_W + HELD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation applied to every cell of a sorted chain in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'b00,
        OP_INSERT = 2'b01,
        OP_PUSH   = 2'b10,
        OP_POPINS = 2'b11
    } chain_op_t;

    typedef struct packed {
        chain_op_t             op;
        logic                  desc;
        logic [SAMPLE_W-1:0]   sample;
    } rms_cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/running_median_sum.sv */
// ----------------------------------------------------------------------------
// running_median_sum
// Streaming lower median with a running sum of medians and its remainder.
// ----------------------------------------------------------------------------
// Usage. Each beat on the s_ channel carries one signed 32-bit sample in
// s_tdata and a start flag in s_tuser. A start flag empties the store and
// zeroes the running sum before the sample goes in. Each accepted beat gives
// exactly one beat on the m_ channel with the lower median, the running sum
// of medians, that sum modulo 10000 (sign of the sum), the held count, and a
// full flag in m_tuser that marks a sample rejected because the store holds
// all 1024 samples already.
// The store is two sorted chains of 512 cells each, the lower half kept in
// descending order and the upper half in ascending order, so both medians
// sit at the chain heads. The insert and any rebalancing finish in the cycle
// the beat is accepted. The remainder of the 42-bit sum is then worked out
// in registered steps (fold to 28 bits, reciprocal multiply, subtract, sign).
// A new sample is taken only once the sequencer is back in idle, after the
// previous result has gone into the output register.
// The result sits in an output register, so the next sample is taken while
// a stalled receiver still holds the previous result; a stall only delays
// the next result once that register is still full.
// Reset (aresetn low, synchronous) empties the store, zeroes the sum and
// drops any result in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_median_sum_macros.svh"

module running_median_sum import rms_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: sample[31:0]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: start_req[0]
    input  wire logic [0:0]            s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // m_tdata: median[31:0], median_total[73:32], total_mod[88:74],
    //          held[99:89], zero fill above
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // m_tuser: full_res[0]
    output logic [0:0]                 m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready
);

    // Sequencer: idle, launch the remainder unit, wait for it, hand over.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          lc_reg, lc_next;
    logic [CNT_W-1:0]          uc_reg, uc_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;

    // Result waiting for its remainder.
    logic signed [SAMPLE_W-1:0] pend_med_reg;
    logic [HELD_W-1:0]          pend_held_reg;
    logic                       pend_full_reg;

    // Output register.
    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] out_med_reg;
    logic signed [TOTAL_W-1:0]  out_total_reg;
    logic signed [MOD_W-1:0]    out_mod_reg;
    logic [HELD_W-1:0]          out_held_reg;
    logic                       out_full_reg;

    logic                       accept;
    logic                       load_out;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
    logic [CNT_W-1:0]           lc_eff, uc_eff;
    logic                       full;
    logic                       go_low;
    logic                       balanced;

    logic signed [SAMPLE_W-1:0] low_head, low_head_next, up_head, up_head_next;
    logic signed [SAMPLE_W-1:0] low_push, med_new;
    chain_op_t                  low_op, up_op;
    rms_cell_ctrl_t             low_ctrl, up_ctrl;

    logic                       mod_done;
    logic signed [MOD_W-1:0]    mod_res;

    assign sample    = $signed(s_tdata[SAMPLE_W-1:0]);
    assign start_req = s_tuser[0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // A start request clears the store before this sample is looked at.
    assign lc_eff   = start_req ? '0 : lc_reg;
    assign uc_eff   = start_req ? '0 : uc_reg;
    assign full     = ({1'b0, lc_eff} + {1'b0, uc_eff}) >= CAPACITY_SUM;
    assign go_low   = (lc_eff == '0) || (sample < low_head);
    assign balanced = (lc_eff == uc_eff);

    // Insert plus rebalance in one step. The lower half keeps the same
    // number of samples as the upper half or one more; whatever crosses over
    // lands at the head of the other chain.
    always_comb begin
        low_op   = OP_HOLD;
        up_op    = OP_HOLD;
        low_push = sample;
        lc_next  = lc_eff;
        uc_next  = uc_eff;
        if (full) begin
            lc_next = lc_reg;
            uc_next = uc_reg;
        end else if (go_low && balanced) begin
            low_op  = OP_INSERT;
            lc_next = lc_eff + CNT_W'(1);
        end else if (go_low) begin
            // Lower head moves up; the sample takes its place below.
            low_op  = OP_POPINS;
            up_op   = OP_PUSH;
            uc_next = uc_eff + CNT_W'(1);
        end else if (!balanced) begin
            up_op   = OP_INSERT;
            uc_next = uc_eff + CNT_W'(1);
        end else if (sample <= up_head) begin
            // The sample is the new upper minimum and drops straight down.
            low_op  = OP_PUSH;
            lc_next = lc_eff + CNT_W'(1);
        end else begin
            // Upper head drops down; the sample takes its place above.
            low_op   = OP_PUSH;
            low_push = up_head;
            up_op    = OP_POPINS;
            lc_next  = lc_eff + CNT_W'(1);
        end
    end

    assign low_ctrl = '{op: accept ? low_op : OP_HOLD, desc: 1'b1, sample: sample};
    assign up_ctrl  = '{op: accept ? up_op  : OP_HOLD, desc: 1'b0, sample: sample};

    rms_chain u_lower (
        .aclk      (aclk),
        .ctrl      (low_ctrl),
        .push_val  (low_push),
        .count     (lc_eff),
        .head      (low_head),
        .head_next (low_head_next)
    );

    rms_chain u_upper (
        .aclk      (aclk),
        .ctrl      (up_ctrl),
        .push_val  (low_head),
        .count     (uc_eff),
        .head      (up_head),
        .head_next (up_head_next)
    );

    assign med_new    = full ? low_head : low_head_next;
    assign total_next = full ? total_reg
                      : ((start_req ? '0 : total_reg)
                         + {{(TOTAL_W - SAMPLE_W){med_new[SAMPLE_W-1]}}, med_new});

    rms_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_LAUNCH),
        .value   (total_reg),
        .done    (mod_done),
        .result  (mod_res)
    );

    assign load_out = (state_reg == ST_HOLD) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_CALC;
            ST_CALC:   if (mod_done) state_next = ST_HOLD;
            ST_HOLD:   if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lc_reg      <= '0;
            uc_reg      <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                lc_reg    <= lc_next;
                uc_reg    <= uc_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_med_reg  <= med_new;
            pend_held_reg <= HELD_W'({1'b0, lc_next} + {1'b0, uc_next});
            pend_full_reg <= full;
        end
        if (load_out) begin
            out_med_reg   <= pend_med_reg;
            out_total_reg <= total_reg;
            out_mod_reg   <= mod_res;
            out_held_reg  <= pend_held_reg;
            out_full_reg  <= pend_full_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_full_reg;
    assign m_tdata  = OUT_DATA_W'({out_held_reg, out_mod_reg, out_total_reg, out_med_reg});

    // The halves stay balanced and the store never exceeds its capacity.
    `RMS_ASSERT_ALWAYS(a_balance, (lc_reg == uc_reg) || (lc_reg == uc_reg + CNT_W'(1)), "halves out of balance")
    `RMS_ASSERT_ALWAYS(a_capacity, ({1'b0, lc_reg} + {1'b0, uc_reg}) <= CAPACITY_SUM, "store over capacity")
    // Only one sample is worked on at a time.
    `RMS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second sample taken while busy")
    // A delivered remainder is always inside the divisor's range.
    `RMS_ASSERT_ALWAYS(a_mod_range, !m_valid_reg || ((out_mod_reg > -MOD_LIMIT) && (out_mod_reg < MOD_LIMIT)), "remainder out of range")
    // After every insert the new lower head stays at or below the new upper head.
    `RMS_ASSERT_ALWAYS(a_order, !accept || full || (uc_next == '0) || (low_head_next <= up_head_next), "lower head above upper head")

endmodule

`default_nettype wire

/* hdl/rms_cell.sv */
// ----------------------------------------------------------------------------
// rms_cell
// One slot of a sorted chain: holds a sample and takes its own, its left or
// its right neighbor's value, or the new sample, as the chain operation asks.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_cell import rms_pkg::*; (
    input  wire logic                       aclk,
    input  wire rms_cell_ctrl_t             ctrl,
    input  wire logic                       occ,
    input  wire logic signed [SAMPLE_W-1:0] left_val,
    input  wire logic                       left_keep,
    input  wire logic signed [SAMPLE_W-1:0] right_val,
    input  wire logic                       right_keep,
    output logic signed [SAMPLE_W-1:0]      val,
    output logic                            keep,
    output logic signed [SAMPLE_W-1:0]      nxt
);

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;
    logic signed [SAMPLE_W-1:0] s;

    assign s   = $signed(ctrl.sample);
    assign val = val_reg;
    assign nxt = val_next;

    // A kept cell stays on the head side of the new sample.
    assign keep = occ && (ctrl.desc ? (val_reg > s) : (val_reg <= s));

    always_comb begin
        case (ctrl.op)
            OP_HOLD:   val_next = val_reg;
            OP_INSERT: val_next = keep ? val_reg : (left_keep ? s : left_val);
            OP_PUSH:   val_next = left_val;
            OP_POPINS: val_next = right_keep ? right_val : (keep ? s : val_reg);
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

/* hdl/rms_chain.sv */
// ----------------------------------------------------------------------------
// rms_chain
// A row of cells holding one half of the store, sorted from the head out.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_chain import rms_pkg::*; (
    input  wire logic                       aclk,
    input  wire rms_cell_ctrl_t             ctrl,
    input  wire logic signed [SAMPLE_W-1:0] push_val,
    input  wire logic [CNT_W-1:0]           count,
    output logic signed [SAMPLE_W-1:0]      head,
    output logic signed [SAMPLE_W-1:0]      head_next
);

    logic signed [SAMPLE_W-1:0] val  [HALF_DEPTH];
    logic signed [SAMPLE_W-1:0] nxt  [HALF_DEPTH];
    logic                       keep [HALF_DEPTH];

    genvar i;
    generate
        for (i = 0; i < HALF_DEPTH; i++) begin : g_cell
            logic signed [SAMPLE_W-1:0] lv;
            logic                       lk;
            logic signed [SAMPLE_W-1:0] rv;
            logic                       rk;

            if (i == 0) begin : g_head
                assign lv = push_val;
                assign lk = 1'b1;
            end else begin : g_body
                assign lv = val[i-1];
                assign lk = keep[i-1];
            end

            if (i == HALF_DEPTH - 1) begin : g_tail
                assign rv = $signed(ctrl.sample);
                assign rk = 1'b0;
            end else begin : g_inner
                assign rv = val[i+1];
                assign rk = keep[i+1];
            end

            rms_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occ        (count > CNT_W'(i)),
                .left_val   (lv),
                .left_keep  (lk),
                .right_val  (rv),
                .right_keep (rk),
                .val        (val[i]),
                .keep       (keep[i]),
                .nxt        (nxt[i])
            );
        end
    endgenerate

    assign head      = val[0];
    assign head_next = nxt[0];

endmodule

`default_nettype wire

/* hdl/rms_mod_unit.sv */
// ----------------------------------------------------------------------------
// rms_mod_unit
// Truncating remainder of a signed total by 10000 in a pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_mod_unit import rms_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [TOTAL_W-1:0] value,
    output logic                           done,
    output logic signed [MOD_W-1:0]        result
);

    logic [MOD_STAGES-1:0]   phase_reg, phase_next;
    logic [TOTAL_W-1:0]      mag_reg;
    logic                    neg_reg;
    logic [FOLD_W-1:0]       fold_reg, fold_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic signed [MOD_W-1:0] res_reg, res_next;

    logic [TOTAL_W-1:0]      mag_in;
    logic [QUOT_W-1:0]       quot;

    assign mag_in = value[TOTAL_W-1] ? (~value + TOTAL_W'(1)) : value;

    // The fold keeps the value below 2^28, well inside the range where the
    // reciprocal gives the exact quotient.
    assign fold_next = FOLD_W'(mag_reg[3*FOLD_CHUNK-1 -: FOLD_CHUNK]) * FOLD_W'(FOLD_HI)
                     + FOLD_W'(mag_reg[2*FOLD_CHUNK-1 -: FOLD_CHUNK]) * FOLD_W'(FOLD_MID)
                     + FOLD_W'(mag_reg[FOLD_CHUNK-1:0]);

    assign prod_next = PROD_W'(fold_reg) * PROD_W'(MOD_RECIP);
    assign quot      = prod_reg[PROD_W-1 -: QUOT_W];
    assign rem_next  = REM_W'(fold_reg - FOLD_W'(quot) * FOLD_W'(MOD_BASE));

    assign res_next = (neg_reg && (rem_reg != '0))
                    ? (MOD_W'(0) - MOD_W'({1'b0, rem_reg}))
                    : MOD_W'({1'b0, rem_reg});

    assign phase_next = {phase_reg[MOD_STAGES-2:0], start};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag_in;
            neg_reg <= value[TOTAL_W-1];
        end
        if (phase_reg[0]) begin
            fold_reg <= fold_next;
        end
        if (phase_reg[1]) begin
            prod_reg <= prod_next;
        end
        if (phase_reg[2]) begin
            rem_reg <= rem_next;
        end
        if (phase_reg[3]) begin
            res_reg <= res_next;
        end
    end

    assign done   = phase_reg[MOD_STAGES-1];
    assign result = res_reg;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running median testbench
// Streams signed samples into the running median block and checks every
// result beat against a queue-based model of the two sorted halves. The run
// starts with a short directed sequence, then random runs of samples, and
// one run that fills the store to capacity and pushes past it.
// ----------------------------------------------------------------------------

module testbench;

    import rms_pkg::*;

    // Bit positions of the result fields inside m_tdata.
    localparam int TOTAL_LO = SAMPLE_W;
    localparam int MOD_LO   = TOTAL_LO + TOTAL_W;
    localparam int HELD_LO  = MOD_LO + MOD_W;

    localparam longint MOD_BASE       = 10000;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     RANDOM_ITEMS   = 750;
    localparam int     CALM_ITEMS     = 650;
    localparam int     FILL_AT        = 250;
    localparam int     DRAIN_CYCLES   = 40;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t sample_q_t[$];

    typedef struct {
        sample_t                   median;
        logic signed [TOTAL_W-1:0] total;
        logic signed [MOD_W-1:0]   rem;
        logic [HELD_W-1:0]         held;
        logic                      full;
    } median_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps the lower and the upper half as ascending queues,
    // so the lower median is always the back of the lower queue. Every
    // accepted sample produces exactly one expected result beat.
    // ------------------------------------------------------------------------
    class median_scoreboard;
        sample_q_t                 low_q;
        sample_q_t                 high_q;
        logic signed [TOTAL_W-1:0] median_sum;
        median_result_t            expected_q[$];
        int unsigned               mismatches;

        function new();
            median_sum = '0;
            mismatches = 0;
        endfunction

        // Equal values land after the ones already held, as the block does.
        function void put_sorted(ref sample_q_t q, input sample_t value);
            int idx;
            idx = q.size();
            while (idx > 0 && q[idx-1] > value)
                idx--;
            q.insert(idx, value);
        endfunction

        function sample_t top_of_lower();
            return (low_q.size() > 0) ? low_q[$] : '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_sample(sample_t value, logic start);
            median_result_t want;
            sample_t        moved;
            longint         wide_sum;

            if (start) begin
                low_q.delete();
                high_q.delete();
                median_sum = '0;
            end
            want.full = (low_q.size() + high_q.size() >= CAPACITY);
            if (!want.full) begin
                // A sample equal to the lower maximum goes to the upper half.
                if (low_q.size() == 0 || value < low_q[$])
                    put_sorted(low_q, value);
                else
                    put_sorted(high_q, value);
                if (low_q.size() == high_q.size() + 2) begin
                    moved = low_q.pop_back();
                    put_sorted(high_q, moved);
                end else if (high_q.size() > low_q.size()) begin
                    moved = high_q.pop_front();
                    put_sorted(low_q, moved);
                end
            end
            want.median = top_of_lower();
            if (!want.full)
                median_sum = median_sum +
                    {{(TOTAL_W-SAMPLE_W){want.median[SAMPLE_W-1]}}, want.median};
            wide_sum    = longint'(median_sum);
            want.total  = median_sum;
            want.rem    = MOD_W'(wide_sum % MOD_BASE);
            want.held   = HELD_W'(low_q.size() + high_q.size());
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [0:0] user);
            median_result_t want;
            median_result_t got;

            got.median = data[SAMPLE_W-1:0];
            got.total  = data[TOTAL_LO +: TOTAL_W];
            got.rem    = data[MOD_LO +: MOD_W];
            got.held   = data[HELD_LO +: HELD_W];
            got.full   = user[0];
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("result beat with no sample pending: median %0d total %0d",
                             got.median, got.total);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.median !== want.median || got.total !== want.total ||
                got.rem !== want.rem || got.held !== want.held ||
                got.full !== want.full) begin
                if (mismatches < 10)
                    $display({"mismatch (expected/actual): median %0d/%0d total %0d/%0d",
                              " mod %0d/%0d held %0d/%0d full %0b/%0b"},
                             want.median, got.median, want.total, got.total,
                             want.rem, got.rem, want.held, got.held,
                             want.full, got.full);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. All inputs start at known values.
    // ------------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // sample[31:0]
    logic [0:0]            s_tuser  = '0;   // start_req[0]
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;         // median, median_total, total_mod, held
    logic [0:0]            m_tuser;         // full_res[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // Idling controls. In the calm part at the end neither side idles.
    bit calm         = 1'b0;
    bit tx_gap_mode  = 1'b0;
    bit rx_stall_mode = 1'b1;

    int unsigned idle_cycles = 0;

    median_scoreboard sb;

    always #1 aclk = ~aclk;

    running_median_sum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ------------------------------------------------------------------------
    // Sending one sample. A random gap may come first, then the beat is held
    // until the block takes it. The scoreboard learns of the sample at the
    // edge where the handshake completes, so expectations stay in order.
    // ------------------------------------------------------------------------
    task automatic send_sample(input sample_t value, input logic start);
        if (!calm && tx_gap_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata  <= value;
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(value, start);
    endtask

    // Sample values: extremes, a narrow range that makes many ties, copies of
    // the current lower maximum, and the full 32-bit range.
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return sample_t'($urandom_range(0, 16)) - sample_t'(8);
            4: return sb.top_of_lower();
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: ready drops at random times while stalls are enabled,
    // and stays high once the calm part begins.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge aclk);
        forever begin
            if (!calm && rx_stall_mode && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if ($urandom_range(0, 15) == 0)
                rx_stall_mode = !rx_stall_mode;
        end
    end

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // The watchdog ends the run once nothing has moved on either channel for
    // far longer than the slowest legal spacing of beats.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int  sent;
        int  run_len;
        bit  fill_done;
        sample_t max_val;
        sample_t min_val;

        sb        = new();
        sent      = 0;
        fill_done = 1'b0;
        max_val   = {1'b0, {(SAMPLE_W-1){1'b1}}};
        min_val   = {1'b1, {(SAMPLE_W-1){1'b0}}};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, alternating bit patterns, samples
        // equal to the lower maximum, and runs whose sum goes negative.
        send_sample('0, 1'b1);
        send_sample(min_val, 1'b0);
        send_sample(max_val, 1'b0);
        send_sample('1, 1'b0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sb.top_of_lower(), 1'b0);
        send_sample(sb.top_of_lower(), 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(max_val, 1'b1);
        send_sample(max_val, 1'b0);
        send_sample(max_val, 1'b0);
        send_sample(min_val, 1'b1);
        send_sample(min_val, 1'b0);
        send_sample(min_val, 1'b0);
        send_sample(sb.top_of_lower(), 1'b0);
        send_sample(-sample_t'(7), 1'b1);
        send_sample(-sample_t'(12345), 1'b0);
        send_sample(sample_t'(10000), 1'b1);
        send_sample('0, 1'b1);

        // Random part: runs of samples, most of them opened by a start flag,
        // with the odd start in the middle of a run.
        while (sent < RANDOM_ITEMS) begin
            tx_gap_mode = ($urandom_range(0, 2) != 0);
            if (sent >= CALM_ITEMS)
                calm = 1'b1;

            if (!fill_done && sent >= FILL_AT) begin
                // Fill the store to capacity, push rejected samples at it,
                // then restart while it is full.
                send_sample(pick_sample(), 1'b1);
                repeat (CAPACITY - 1) send_sample(pick_sample(), 1'b0);
                repeat (8) send_sample(sample_t'($urandom), 1'b0);
                send_sample(pick_sample(), 1'b1);
                repeat (4) send_sample(pick_sample(), 1'b0);
                fill_done = 1'b1;
            end

            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(1, 40);
            send_sample(pick_sample(), $urandom_range(0, 3) != 0);
            sent++;
            for (int i = 1; i < run_len; i++) begin
                send_sample(pick_sample(), $urandom_range(0, 29) == 0);
                sent++;
            end
        end

        s_tvalid <= 1'b0;

        // Drain: wait for every result, then a little longer to catch any
        // stray beat.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/rms_pkg.sv
hdl/rms_cell.sv
hdl/rms_chain.sv
hdl/rms_mod_unit.sv
hdl/running_median_sum.sv
sim/testbench.sv
